// ----- rtl/core/convex_plane_set_merge_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef CONVEX_PLANE_SET_MERGE_UNIT_DEFINES_SVH
`define CONVEX_PLANE_SET_MERGE_UNIT_DEFINES_SVH

// same-cycle implication under the block clock and reset
`define CPSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cpsm assertion failed");

// next-cycle implication under the block clock and reset
`define CPSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cpsm assertion failed");

`endif

// ----- rtl/core/cpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// cpsm_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package cpsm_pkg;

    localparam int MAX_PLANES_DEF = 64;
    localparam logic [30:0] THR_RESET = 31'd1073527076;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_RAISED    = 3'd1;
    localparam logic [2:0] ST_UNCHANGED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ZERO      = 3'd4;

    localparam logic [1:0] MODE_SQ   = 2'd0;
    localparam logic [1:0] MODE_DIST = 2'd1;
    localparam logic [1:0] MODE_DOT  = 2'd2;

    localparam logic [1:0] FIN_ZERO   = 2'd0;
    localparam logic [1:0] FIN_FULL   = 2'd1;
    localparam logic [1:0] FIN_APPEND = 2'd2;
    localparam logic [1:0] FIN_MERGE  = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       norm_shift;
        logic       acc_clr;
        logic       acc_add;
        logic [1:0] mul_mode;
        logic [1:0] mul_sel;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic [1:0] comp;
        logic       dist_save;
        logic       scan_clear;
        logic       scan_next;
        logic       mem_rd;
        logic       fin;
        logic [1:0] fin_code;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic norm_ok;
        logic scan_end;
        logic match;
        logic full;
    } t_sts;

endpackage

// ----- rtl/core/cpsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpsm_ctrl
// sequencer: normalize, square root, divide, distance, table scan, finish
// ----------------------------------------------------------------------------
module cpsm_ctrl
    import cpsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_NORM  = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_RINIT = 4'd4;
    localparam logic [3:0] S_ROOT  = 4'd5;
    localparam logic [3:0] S_DIVI  = 4'd6;
    localparam logic [3:0] S_DIVS  = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_DIST  = 4'd9;
    localparam logic [3:0] S_DSAV  = 4'd10;
    localparam logic [3:0] S_SCAN  = 4'd11;
    localparam logic [3:0] S_DOT   = 4'd12;
    localparam logic [3:0] S_TEST  = 4'd13;

    localparam logic [4:0] MAC_LAST  = 5'd3;
    localparam logic [4:0] ROOT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd30;
    localparam logic [1:0] COMP_LAST = 2'd2;

    logic [3:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_comp, n_comp;

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_comp  = r_comp;
        o_cmd   = '0;
        o_cmd.comp    = r_comp;
        o_cmd.mul_sel = r_cnt[1:0];
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.zero) begin
                    o_cmd.fin      = 1'b1;
                    o_cmd.fin_code = FIN_ZERO;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (i_sts.norm_ok) begin
                    n_cnt   = '0;
                    n_state = S_SQ;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            S_SQ, S_DIST, S_DOT: begin
                // issue three products, accumulate each in the cycle after
                o_cmd.mul_mode = (r_state == S_SQ)   ? MODE_SQ :
                                 (r_state == S_DIST) ? MODE_DIST : MODE_DOT;
                o_cmd.acc_clr = (r_cnt == '0);
                o_cmd.acc_add = (r_cnt != '0);
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == MAC_LAST) begin
                    n_state = (r_state == S_SQ)   ? S_RINIT :
                              (r_state == S_DIST) ? S_DSAV : S_TEST;
                end
            end
            S_RINIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt   = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == ROOT_LAST) begin
                    n_comp  = '0;
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                o_cmd.div_store = 1'b1;
                if (r_comp == COMP_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DIST;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = S_DIVI;
                end
            end
            S_DSAV: begin
                o_cmd.dist_save  = 1'b1;
                o_cmd.scan_clear = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    o_cmd.fin      = 1'b1;
                    o_cmd.fin_code = i_sts.full ? FIN_FULL : FIN_APPEND;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DOT;
                end
            end
            S_TEST: begin
                if (i_sts.match) begin
                    o_cmd.fin      = 1'b1;
                    o_cmd.fin_code = FIN_MERGE;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/cpsm_datapath.sv -----
// ----------------------------------------------------------------------------
// cpsm_datapath
// shared multiplier/accumulator, bit-serial root and divider, plane table
// ----------------------------------------------------------------------------
module cpsm_datapath
    import cpsm_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [30:0]        i_cfg_data,
    input  logic signed [31:0] i_normal_x,
    input  logic signed [31:0] i_normal_y,
    input  logic signed [31:0] i_normal_z,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [5:0]         o_plane_index,
    output logic [6:0]         o_plane_count,
    output logic signed [31:0] o_plane_distance
);

    localparam int IW = $clog2(MAX_PLANES);
    localparam int CW = $clog2(MAX_PLANES + 1);

    logic [30:0] r_thr;

    logic [31:0]        r_mag [3];
    logic               r_neg [3];
    logic signed [31:0] r_p   [3];
    logic signed [31:0] r_u   [3];
    logic signed [31:0] r_rd_n[3];
    logic signed [31:0] r_rd_d;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] r_prod;
    logic [63:0]        r_acc;

    logic [63:0] r_sx;
    logic [34:0] r_srem;
    logic [31:0] r_root;

    logic [31:0] r_drem;
    logic [30:0] r_dlo;
    logic [30:0] r_q;

    logic signed [31:0] r_d;
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      r_count;

    logic signed [31:0] mem_nx [MAX_PLANES];
    logic signed [31:0] mem_ny [MAX_PLANES];
    logic signed [31:0] mem_nz [MAX_PLANES];
    logic signed [31:0] mem_px [MAX_PLANES];
    logic signed [31:0] mem_py [MAX_PLANES];
    logic signed [31:0] mem_pz [MAX_PLANES];
    logic signed [31:0] mem_d  [MAX_PLANES];

    logic [2:0]         r_o_status;
    logic [5:0]         r_o_idx;
    logic [6:0]         r_o_cnt;
    logic signed [31:0] r_o_dist;
    logic               r_o_done;

    logic signed [31:0] in_n [3];
    logic signed [31:0] in_p [3];

    assign in_n[0] = i_normal_x;
    assign in_n[1] = i_normal_y;
    assign in_n[2] = i_normal_z;
    assign in_p[0] = i_point_x;
    assign in_p[1] = i_point_y;
    assign in_p[2] = i_point_z;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // operand capture and normalizing shift
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.capture) begin
                r_mag[c] <= in_n[c][31] ? 32'(-in_n[c]) : 32'(in_n[c]);
                r_neg[c] <= in_n[c][31];
                r_p[c]   <= in_p[c];
            end else if (i_cmd.norm_shift) begin
                r_mag[c] <= {r_mag[c][30:0], 1'b0};
            end
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_sel)
            2'd0: begin
                mul_a = (i_cmd.mul_mode == MODE_SQ) ? $signed({1'b0, r_mag[0]})
                                                    : 33'(r_u[0]);
                mul_b = (i_cmd.mul_mode == MODE_SQ)   ? $signed({1'b0, r_mag[0]}) :
                        (i_cmd.mul_mode == MODE_DIST) ? 33'(r_p[0]) : 33'(r_rd_n[0]);
            end
            2'd1: begin
                mul_a = (i_cmd.mul_mode == MODE_SQ) ? $signed({1'b0, r_mag[1]})
                                                    : 33'(r_u[1]);
                mul_b = (i_cmd.mul_mode == MODE_SQ)   ? $signed({1'b0, r_mag[1]}) :
                        (i_cmd.mul_mode == MODE_DIST) ? 33'(r_p[1]) : 33'(r_rd_n[1]);
            end
            2'd2: begin
                mul_a = (i_cmd.mul_mode == MODE_SQ) ? $signed({1'b0, r_mag[2]})
                                                    : 33'(r_u[2]);
                mul_b = (i_cmd.mul_mode == MODE_SQ)   ? $signed({1'b0, r_mag[2]}) :
                        (i_cmd.mul_mode == MODE_DIST) ? 33'(r_p[2]) : 33'(r_rd_n[2]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sum of squares may exceed the signed range; bits are kept modulo 2^64
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod[63:0];
        end
    end

    // square root, two radicand bits a step
    logic [34:0] s_rem2, s_trial;
    logic        s_ge;
    assign s_rem2  = {r_srem[32:0], r_sx[63:62]};
    assign s_trial = {1'b0, r_root, 2'b01};
    assign s_ge    = (s_rem2 >= s_trial);

    // restoring divide, one quotient bit a step
    logic [62:0] d_num;
    logic [32:0] d_t;
    logic        d_ge;
    logic [32:0] d_diff;
    assign d_num  = {1'b0, r_mag[i_cmd.comp], 30'b0} + {32'b0, r_root[31:1]};
    assign d_t    = {r_drem, r_dlo[30]};
    assign d_ge   = (d_t >= {1'b0, r_root});
    assign d_diff = d_t - {1'b0, r_root};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_sx   <= r_acc;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sx   <= {r_sx[61:0], 2'b00};
            r_srem <= s_ge ? (s_rem2 - s_trial) : s_rem2;
            r_root <= {r_root[30:0], s_ge};
        end
        if (i_cmd.div_init) begin
            r_drem <= d_num[62:31];
            r_dlo  <= d_num[30:0];
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            r_drem <= d_ge ? d_diff[31:0] : d_t[31:0];
            r_dlo  <= {r_dlo[29:0], 1'b0};
            r_q    <= {r_q[29:0], d_ge};
        end
        if (i_cmd.div_store) begin
            for (int c = 0; c < 3; c++) begin
                if (i_cmd.comp == 2'(c)) begin
                    r_u[c] <= r_neg[c] ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
                end
            end
        end
    end

    // rounded, saturated distance
    logic [63:0]        dist_sum;
    logic signed [33:0] dist_sh;
    logic signed [31:0] dist_sat;
    assign dist_sum = r_acc + 64'd536870912;
    assign dist_sh  = $signed(dist_sum[63:30]);
    always_comb begin
        if (dist_sh[33:31] == 3'b000 || dist_sh[33:31] == 3'b111) begin
            dist_sat = dist_sh[31:0];
        end else if (dist_sh[33]) begin
            dist_sat = 32'sh8000_0000;
        end else begin
            dist_sat = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dist_save) begin
            r_d <= dist_sat;
        end
    end

    // table read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_n[0] <= mem_nx[r_k[IW-1:0]];
            r_rd_n[1] <= mem_ny[r_k[IW-1:0]];
            r_rd_n[2] <= mem_nz[r_k[IW-1:0]];
            r_rd_d    <= mem_d[r_k[IW-1:0]];
        end
    end

    logic          fin_append, fin_merge, raise;
    logic [IW-1:0] wr_addr;
    logic [CW-1:0] cnt_after;
    logic [IW+5:0] idx_ext;
    logic [CW+6:0] cnt_ext;
    assign fin_append = i_cmd.fin && (i_cmd.fin_code == FIN_APPEND);
    assign fin_merge  = i_cmd.fin && (i_cmd.fin_code == FIN_MERGE);
    assign raise      = (r_d > r_rd_d);
    assign wr_addr    = fin_append ? r_count[IW-1:0] : r_k[IW-1:0];
    assign cnt_after  = fin_append ? r_count + CW'(1) : r_count;
    assign idx_ext    = {6'b0, wr_addr};
    assign cnt_ext    = {7'b0, cnt_after};

    // table write
    always_ff @(posedge i_clk) begin
        if (fin_append) begin
            mem_nx[wr_addr] <= r_u[0];
            mem_ny[wr_addr] <= r_u[1];
            mem_nz[wr_addr] <= r_u[2];
        end
        if (fin_append || (fin_merge && raise)) begin
            mem_px[wr_addr] <= r_p[0];
            mem_py[wr_addr] <= r_p[1];
            mem_pz[wr_addr] <= r_p[2];
            mem_d[wr_addr]  <= r_d;
        end
    end

    // scan index and plane count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_k     <= '0;
        end else begin
            if (i_cmd.scan_clear) begin
                r_k <= '0;
            end else if (i_cmd.scan_next) begin
                r_k <= r_k + CW'(1);
            end
            if (fin_append) begin
                r_count <= cnt_after;
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_done <= 1'b0;
        end else begin
            r_o_done <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_o_cnt <= cnt_ext[6:0];
            unique case (i_cmd.fin_code)
                FIN_ZERO: begin
                    r_o_status <= ST_ZERO;
                    r_o_idx    <= '0;
                    r_o_dist   <= '0;
                end
                FIN_FULL: begin
                    r_o_status <= ST_FULL;
                    r_o_idx    <= '0;
                    r_o_dist   <= '0;
                end
                FIN_APPEND: begin
                    r_o_status <= ST_NEW;
                    r_o_idx    <= idx_ext[5:0];
                    r_o_dist   <= r_d;
                end
                FIN_MERGE: begin
                    r_o_status <= raise ? ST_RAISED : ST_UNCHANGED;
                    r_o_idx    <= idx_ext[5:0];
                    r_o_dist   <= raise ? r_d : r_rd_d;
                end
                default: begin
                    r_o_status <= ST_ZERO;
                    r_o_idx    <= '0;
                    r_o_dist   <= '0;
                end
            endcase
        end
    end

    assign o_sts.zero     = (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
    assign o_sts.norm_ok  = |{r_mag[0][31:30], r_mag[1][31:30], r_mag[2][31:30]};
    assign o_sts.scan_end = (r_k >= r_count);
    assign o_sts.match    = ($signed(r_acc) >= $signed({3'b000, r_thr, 30'b0}));
    assign o_sts.full     = (r_count == CW'(MAX_PLANES));

    assign o_done           = r_o_done;
    assign o_status         = r_o_status;
    assign o_plane_index    = r_o_idx;
    assign o_plane_count    = r_o_cnt;
    assign o_plane_distance = r_o_dist;

endmodule

// ----- rtl/core/convex_plane_set_merge_unit.sv -----
// ----------------------------------------------------------------------------
// convex_plane_set_merge_unit
// merges plane beats into a table of unique unit-normal planes
// ----------------------------------------------------------------------------
// usage:
//   drive the normal and point ports and raise start while busy is low; the
//   beat is taken at that edge and busy stays high until the result cycle.
//   one result per item appears for a single cycle with o_done high; the
//   receiver cannot stall it, so it must take the beat in that cycle.
//   the threshold is written on i_cfg_data when i_cfg_valid is high
//   (o_cfg_ready is always high); write it only while busy is low.
// sequence:
//   the time from the accepting edge to the o_done cycle grows with the
//   normalizing shifts (0..30) and with the planes compared, and is set by
//   the bit-serial root (32 steps), the three 31-step divides and the single
//   shared multiplier (3 products per plane); a zero normal is reported
//   straight from the zero check.
//   one item at a time; the next can be taken in the o_done cycle.
// reset: synchronous, clears the plane count and restores the threshold;
//   table contents are not cleared since only written slots are read.
// ----------------------------------------------------------------------------
module convex_plane_set_merge_unit
    import cpsm_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_normal_x,
    input  logic signed [31:0] i_normal_y,
    input  logic signed [31:0] i_normal_z,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_cfg_data,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [5:0]         o_plane_index,
    output logic [6:0]         o_plane_count,
    output logic signed [31:0] o_plane_distance
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    cpsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cpsm_datapath #(
        .MAX_PLANES (MAX_PLANES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_normal_x       (i_normal_x),
        .i_normal_y       (i_normal_y),
        .i_normal_z       (i_normal_z),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_point_z        (i_point_z),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_plane_index    (o_plane_index),
        .o_plane_count    (o_plane_count),
        .o_plane_distance (o_plane_distance)
    );

endmodule

// ----- rtl/core/cpsm_checker.sv -----
// ----------------------------------------------------------------------------
// cpsm_checker
// port-level checks for the plane merge unit, bound to the top level
// ----------------------------------------------------------------------------
`include "convex_plane_set_merge_unit_defines.svh"

module cpsm_checker
    import cpsm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic [2:0]         o_status,
    input logic [5:0]         o_plane_index,
    input logic [6:0]         o_plane_count,
    input logic signed [31:0] o_plane_distance
);

    // a taken beat keeps the unit busy until its result
    `CPSM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // the result beat comes out once the unit is free again
    `CPSM_ASSERT_NOW(a_done_idle, o_done, !busy)
    // one result per item, never two in a row
    `CPSM_ASSERT_NEXT(a_done_single, o_done, !o_done)
    // rejected items report slot 0 and distance 0
    `CPSM_ASSERT_NOW(a_reject_index, o_done && o_status >= ST_FULL, o_plane_index == 6'd0)
    `CPSM_ASSERT_NOW(a_reject_dist, o_done && o_status >= ST_FULL, o_plane_distance == 32'sd0)

endmodule

bind convex_plane_set_merge_unit cpsm_checker u_cpsm_checker (.*);
